// File: design/windowed_moving_average_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed moving average
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MOVING_AVERAGE_DEFINES_SVH
`define WINDOWED_MOVING_AVERAGE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define WMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define WMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg
// Sizes, limits and controller states of the windowed moving average.
// ----------------------------------------------------------------------------
package wma_pkg;

  // Window depth and sample width
  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 12;

  // Derived widths
  localparam int COUNT_W   = $clog2(WINDOW + 1);
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = SAMPLE_BITS + COUNT_W;
  localparam int PROD_W    = SUM_W + 4;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // Result field widths
  localparam int AVG_W  = 16;
  localparam int HELD_W = 5;
  localparam int CMP_W  = (PROD_W > AVG_W) ? PROD_W : AVG_W;

  // Stream bus widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((AVG_W + HELD_W + 7) / 8) * 8;

  // Scale factor and limits
  localparam int SCALE = 10;
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam longint unsigned SUM_MAX =
    longint'(WINDOW) * ((64'd1 << SAMPLE_BITS) - 64'd1);

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_SCALE  = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } wma_state_t;

endpackage

// File: design/wma_ram.sv
// ----------------------------------------------------------------------------
// wma_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/windowed_moving_average.sv
// ----------------------------------------------------------------------------
// windowed_moving_average
// Boxcar average over the last WINDOW samples, scaled by ten.
// ----------------------------------------------------------------------------
// Each input beat carries one sample; each yields one output beat with the
// truncated average of the held samples times ten and the number of samples
// held (1..WINDOW). Samples sit in a ring RAM; the running sum is updated
// by reading the oldest entry and writing the new one at the ring pointer.
// Each item passes through these steps in order: accept, RAM
// read-modify-write of the sum, scaling, then a restoring divider that
// retires one quotient bit per cycle over the PROD_W-bit scaled sum, then
// handoff to the output register. The handoff waits for as long as the
// previous result still sits unaccepted in the output register. A new beat
// is taken only once the previous item has been handed off, and may be
// accepted while that result still waits in the output register.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "windowed_moving_average_defines.svh"

module windowed_moving_average (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] sample
  input  logic [wma_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] average_x10, [20:16] samples_held
  output logic [wma_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  wma_pkg::wma_state_t state_r, state_nxt;

  logic [wma_pkg::SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [wma_pkg::PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [wma_pkg::COUNT_W-1:0]     fill_r, fill_nxt;
  logic [wma_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [wma_pkg::PROD_W-1:0]      quo_r, quo_nxt;
  logic [wma_pkg::COUNT_W-1:0]     rem_r, rem_nxt;
  logic [wma_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [wma_pkg::AVG_W-1:0]       out_avg_r, out_avg_nxt;
  logic [wma_pkg::HELD_W-1:0]      out_held_r, out_held_nxt;

  logic                            full;
  logic                            ram_we;
  logic [wma_pkg::SAMPLE_BITS-1:0] ram_rdata;
  logic [wma_pkg::COUNT_W:0]       div_shift;
  logic                            div_ge;
  logic                            slot_free;

  // Sample ring
  wma_ram #(
    .WIDTH (wma_pkg::SAMPLE_BITS),
    .DEPTH (wma_pkg::WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (sample_r),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign full      = (fill_r == wma_pkg::COUNT_W'(wma_pkg::WINDOW));
  assign ram_we    = (state_r == wma_pkg::S_UPDATE);
  assign div_shift = {rem_r, quo_r[wma_pkg::PROD_W-1]};
  assign div_ge    = (div_shift >= {1'b0, fill_r});
  assign slot_free = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == wma_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = wma_pkg::OUT_TDATA_W'({out_held_r, out_avg_r});

  // Sequencer: accept, update sum, scale, divide, hand off
  always_comb begin
    state_nxt      = state_r;
    sample_nxt     = sample_r;
    ptr_nxt        = ptr_r;
    fill_nxt       = fill_r;
    sum_nxt        = sum_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_avg_nxt    = out_avg_r;
    out_held_nxt   = out_held_r;

    unique case (state_r)
      wma_pkg::S_IDLE: begin
        // Capture the beat; the RAM reads the oldest entry meanwhile
        if (in_tvalid) begin
          sample_nxt = in_tdata[wma_pkg::SAMPLE_BITS-1:0];
          state_nxt  = wma_pkg::S_UPDATE;
        end
      end
      wma_pkg::S_UPDATE: begin
        // Drop the oldest sample once full, add the new one, advance the ring
        if (full) begin
          sum_nxt = sum_r - wma_pkg::SUM_W'(ram_rdata) + wma_pkg::SUM_W'(sample_r);
        end else begin
          sum_nxt  = sum_r + wma_pkg::SUM_W'(sample_r);
          fill_nxt = fill_r + 1'b1;
        end
        if (ptr_r == wma_pkg::PTR_W'(wma_pkg::WINDOW - 1)) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
        state_nxt = wma_pkg::S_SCALE;
      end
      wma_pkg::S_SCALE: begin
        // Load the divider with sum times ten
        quo_nxt   = wma_pkg::PROD_W'(sum_r) * wma_pkg::PROD_W'(wma_pkg::SCALE);
        rem_nxt   = '0;
        cnt_nxt   = wma_pkg::DIV_CNT_W'(wma_pkg::PROD_W - 1);
        state_nxt = wma_pkg::S_DIV;
      end
      wma_pkg::S_DIV: begin
        // Retire one quotient bit per cycle
        if (div_ge) begin
          rem_nxt = wma_pkg::COUNT_W'(div_shift - {1'b0, fill_r});
        end else begin
          rem_nxt = div_shift[wma_pkg::COUNT_W-1:0];
        end
        quo_nxt = {quo_r[wma_pkg::PROD_W-2:0], div_ge};
        if (cnt_r == '0) begin
          state_nxt = wma_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      wma_pkg::S_DONE: begin
        // Saturate and hand the result to the output register
        if (slot_free) begin
          if (wma_pkg::CMP_W'(quo_r) > wma_pkg::CMP_W'(wma_pkg::AVG_MAX)) begin
            out_avg_nxt = wma_pkg::AVG_MAX;
          end else begin
            out_avg_nxt = wma_pkg::AVG_W'(quo_r);
          end
          out_held_nxt   = wma_pkg::HELD_W'(fill_r);
          out_tvalid_nxt = 1'b1;
          state_nxt      = wma_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wma_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wma_pkg::S_IDLE;
      ptr_r        <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_avg_r  <= out_avg_nxt;
    out_held_r <= out_held_nxt;
  end

  // Checks
  `WMA_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= wma_pkg::COUNT_W'(wma_pkg::WINDOW),
    "fill count above window depth")
  `WMA_ASSERT_SAME(a_ptr_tracks_fill, !full, ptr_r == wma_pkg::PTR_W'(fill_r),
    "ring pointer differs from fill count while filling")
  `WMA_ASSERT_SAME(a_sum_bound, 1'b1, sum_r <= wma_pkg::SUM_W'(wma_pkg::SUM_MAX),
    "running sum above full-scale window sum")
  `WMA_ASSERT_NEXT(a_accept_update, in_tvalid && in_tready,
    state_r == wma_pkg::S_UPDATE, "accepted beat not followed by sum update")
  `WMA_ASSERT_SAME(a_held_nonzero, out_tvalid_r, out_held_r != '0,
    "result offered with no samples held")

endmodule
